// File: sv/ppr_pkg.sv
// shared types and constants for the phone prefix range lookup
package ppr_pkg;

    localparam int KEY_W    = 24;
    localparam int IDX_W    = 19;
    localparam int REGION_W = 16;
    localparam int CARR_W   = 8;
    localparam int PCODE_W  = 10;
    localparam int QUOT_W   = 11;
    localparam int REC_W    = KEY_W + REGION_W + CARR_W;
    localparam int PENT_W   = 2 * IDX_W;
    localparam int WIDE_W   = 25;

    // key / 10000 as (key * DIV_MULT) >> DIV_SHIFT, exact for any 24-bit key
    localparam logic [KEY_W-1:0] DIV_MULT  = 24'd13743896;
    localparam int               DIV_SHIFT = 37;

    typedef enum logic [1:0] {
        CMD_LOAD_PREFIX = 2'd0,
        CMD_LOAD_RECORD = 2'd1,
        CMD_QUERY       = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PREF,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// File: sv/phone_prefix_range_lookup.sv
// top level: prefix table, record store and binary search sequencer
//
// usage: one input stream carries load and query transactions, selected by s_tuser.
// a prefix load writes the first/last record index of a three-digit prefix, a record
// load writes number, region and carrier at a record index; neither gives a result.
// a query gives exactly one result transaction on the output stream: hit flag plus
// region and carrier codes (zero on a miss).
// loads are taken back to back. a query passes the prefix divide and prefix table
// read (DIV, PREF states), then a PROBE and a CMP state for each binary search probe
// through the record store read port (up to 20 probes over a 2^19 range), then
// DONE to load the output register. s_tready is low while a query is in flight.
// after reset the prefix table is swept to zero, one entry a cycle, with s_tready
// low. the record store is not cleared.
// a stalled receiver holds the result in the output register; further loads are
// still taken, and the next query waits at its end until the register is free.
module phone_prefix_range_lookup
#(
    parameter int RECORD_DEPTH = 524288,
    parameter int PREFIX_COUNT = 1000
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // prefix_code, range_first, range_last, slot_index, slot_number, slot_region,
    // slot_carrier, query_number, zero pad
    input  logic [143:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, region_out, carrier_out, zero pad
    output logic [31:0]  m_tdata
);

    localparam int AW = $clog2(RECORD_DEPTH);
    localparam int PW = (PREFIX_COUNT > 1) ? $clog2(PREFIX_COUNT) : 1;
    localparam logic [PW-1:0] PLAST = PW'(PREFIX_COUNT - 1);
    localparam logic [ppr_pkg::WIDE_W-1:0] DEPTH_W = ppr_pkg::WIDE_W'(RECORD_DEPTH);
    localparam logic [ppr_pkg::QUOT_W-1:0] PCOUNT_W = ppr_pkg::QUOT_W'(PREFIX_COUNT);

    // input fields
    logic [ppr_pkg::PCODE_W-1:0]  prefix_code;
    logic [ppr_pkg::IDX_W-1:0]    range_first;
    logic [ppr_pkg::IDX_W-1:0]    range_last;
    logic [ppr_pkg::IDX_W-1:0]    slot_index;
    logic [ppr_pkg::KEY_W-1:0]    slot_number;
    logic [ppr_pkg::REGION_W-1:0] slot_region;
    logic [ppr_pkg::CARR_W-1:0]   slot_carrier;
    logic [ppr_pkg::KEY_W-1:0]    query_number;
    ppr_pkg::cmd_t                cmd;

    assign prefix_code  = s_tdata[9:0];
    assign range_first  = s_tdata[28:10];
    assign range_last   = s_tdata[47:29];
    assign slot_index   = s_tdata[66:48];
    assign slot_number  = s_tdata[90:67];
    assign slot_region  = s_tdata[106:91];
    assign slot_carrier = s_tdata[114:107];
    assign query_number = s_tdata[138:115];
    assign cmd          = ppr_pkg::cmd_t'(s_tuser);

    // memories
    logic [ppr_pkg::PENT_W-1:0] prefix_mem [PREFIX_COUNT];
    logic [ppr_pkg::REC_W-1:0]  record_mem [RECORD_DEPTH];
    logic [ppr_pkg::PENT_W-1:0] pref_rd_reg;
    logic [ppr_pkg::REC_W-1:0]  rec_rd_reg;

    logic                       pref_we;
    logic [PW-1:0]              pref_waddr;
    logic [ppr_pkg::PENT_W-1:0] pref_wdata;
    logic [PW-1:0]              pref_raddr;
    logic                       rec_we;
    logic [AW-1:0]              rec_waddr;
    logic [AW-1:0]              rec_raddr;

    // sequencer state
    ppr_pkg::state_t             state_reg, state_next;
    logic [PW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [ppr_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                        pref_ok_reg, pref_ok_next;
    logic signed [20:0]          lo_reg, lo_next;
    logic signed [20:0]          hi_reg, hi_next;
    logic [ppr_pkg::IDX_W-1:0]   mid_reg, mid_next;
    logic                        oob_reg, oob_next;
    logic                        single_reg, single_next;
    logic                        hit_reg, hit_next;
    logic [ppr_pkg::REGION_W-1:0] region_reg, region_next;
    logic [ppr_pkg::CARR_W-1:0]  carrier_reg, carrier_next;
    logic                        m_valid_reg, m_valid_next;

    logic [ppr_pkg::QUOT_W-1:0]  quot;
    logic                        accept;
    logic signed [20:0]          sum;
    logic [ppr_pkg::IDX_W-1:0]   mid_calc;
    logic [ppr_pkg::WIDE_W-1:0]  slot_wide;
    logic [ppr_pkg::WIDE_W-1:0]  mid_wide;
    logic [ppr_pkg::KEY_W-1:0]   probe_num;

    ppr_prefix_div u_div
    (
        .clk  (clk),
        .key  (query_number),
        .quot (quot)
    );

    assign s_tready = (state_reg == ppr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign sum       = lo_reg + hi_reg;
    assign slot_wide = ppr_pkg::WIDE_W'(slot_index);
    assign mid_wide  = ppr_pkg::WIDE_W'(mid_calc);
    assign probe_num = oob_reg ? '0 : rec_rd_reg[ppr_pkg::REC_W-1:ppr_pkg::REC_W-ppr_pkg::KEY_W];

    always_comb
    begin
        if (single_reg)
        begin
            mid_calc = lo_reg[ppr_pkg::IDX_W-1:0];
        end
        else
        begin
            mid_calc = sum[ppr_pkg::IDX_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pref_we)
        begin
            prefix_mem[pref_waddr] <= pref_wdata;
        end
        pref_rd_reg <= prefix_mem[pref_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            record_mem[rec_waddr] <= {slot_number, slot_region, slot_carrier};
        end
        rec_rd_reg <= record_mem[rec_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ppr_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        pref_ok_reg <= pref_ok_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        oob_reg     <= oob_next;
        single_reg  <= single_next;
        hit_reg     <= hit_next;
        region_reg  <= region_next;
        carrier_reg <= carrier_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        key_next     = key_reg;
        pref_ok_next = pref_ok_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        oob_next     = oob_reg;
        single_next  = single_reg;
        hit_next     = hit_reg;
        region_next  = region_reg;
        carrier_next = carrier_reg;
        m_valid_next = m_valid_reg && !m_tready;

        pref_we    = 1'b0;
        pref_waddr = prefix_code[PW-1:0];
        pref_wdata = {range_first, range_last};
        pref_raddr = quot[PW-1:0];
        rec_we     = 1'b0;
        rec_waddr  = slot_wide[AW-1:0];
        rec_raddr  = mid_wide[AW-1:0];

        unique case (state_reg)
            ppr_pkg::ST_CLEAR:
            begin
                pref_we    = 1'b1;
                pref_waddr = clr_cnt_reg;
                pref_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PLAST)
                begin
                    state_next = ppr_pkg::ST_IDLE;
                end
            end
            ppr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        ppr_pkg::CMD_LOAD_PREFIX:
                        begin
                            pref_we = ({1'b0, prefix_code} < PCOUNT_W);
                        end
                        ppr_pkg::CMD_LOAD_RECORD:
                        begin
                            rec_we = (slot_wide < DEPTH_W);
                        end
                        ppr_pkg::CMD_QUERY:
                        begin
                            key_next   = query_number;
                            state_next = ppr_pkg::ST_DIV;
                        end
                        default:
                        begin
                            state_next = ppr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ppr_pkg::ST_DIV:
            begin
                // quotient is ready, read the prefix entry
                pref_ok_next = (quot < PCOUNT_W);
                state_next   = ppr_pkg::ST_PREF;
            end
            ppr_pkg::ST_PREF:
            begin
                lo_next     = 21'(pref_rd_reg[ppr_pkg::PENT_W-1:ppr_pkg::IDX_W]);
                hi_next     = 21'(pref_rd_reg[ppr_pkg::IDX_W-1:0]);
                single_next = (pref_rd_reg[ppr_pkg::PENT_W-1:ppr_pkg::IDX_W]
                               == pref_rd_reg[ppr_pkg::IDX_W-1:0]);
                if (!pref_ok_reg || pref_rd_reg[ppr_pkg::IDX_W-1:0] == '0)
                begin
                    hit_next   = 1'b0;
                    state_next = ppr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ppr_pkg::ST_PROBE;
                end
            end
            ppr_pkg::ST_PROBE:
            begin
                if (!single_reg && lo_reg > hi_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = ppr_pkg::ST_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    oob_next   = (mid_wide >= DEPTH_W);
                    state_next = ppr_pkg::ST_CMP;
                end
            end
            ppr_pkg::ST_CMP:
            begin
                if (single_reg || probe_num == key_reg)
                begin
                    hit_next   = 1'b1;
                    state_next = ppr_pkg::ST_DONE;
                end
                else if (probe_num > key_reg)
                begin
                    hi_next    = 21'(mid_reg) - 21'sd1;
                    state_next = ppr_pkg::ST_PROBE;
                end
                else
                begin
                    lo_next    = 21'(mid_reg) + 21'sd1;
                    state_next = ppr_pkg::ST_PROBE;
                end
                // out of range probes read as an all-zero record
                region_next  = oob_reg ? '0
                             : rec_rd_reg[ppr_pkg::REGION_W+ppr_pkg::CARR_W-1:ppr_pkg::CARR_W];
                carrier_next = oob_reg ? '0 : rec_rd_reg[ppr_pkg::CARR_W-1:0];
            end
            ppr_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ppr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppr_pkg::ST_IDLE;
            end
        endcase
    end

    // result payload is loaded with the valid flag in the done state
    logic                         out_hit_reg;
    logic [ppr_pkg::REGION_W-1:0] out_region_reg;
    logic [ppr_pkg::CARR_W-1:0]   out_carrier_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ppr_pkg::ST_DONE && (!m_valid_reg || m_tready))
        begin
            out_hit_reg     <= hit_reg;
            out_region_reg  <= hit_reg ? region_reg : '0;
            out_carrier_reg <= hit_reg ? carrier_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_carrier_reg, out_region_reg, out_hit_reg};

endmodule

// File: sv/ppr_prefix_div.sv
// prefix extraction: number divided by ten thousand through a reciprocal multiply
module ppr_prefix_div
(
    input  logic                          clk,
    input  logic [ppr_pkg::KEY_W-1:0]     key,
    output logic [ppr_pkg::QUOT_W-1:0]    quot
);

    logic [2*ppr_pkg::KEY_W-1:0] prod;
    logic [ppr_pkg::QUOT_W-1:0]  quot_reg;

    assign prod = key * ppr_pkg::DIV_MULT;

    always_ff @(posedge clk)
    begin
        quot_reg <= prod[ppr_pkg::DIV_SHIFT+ppr_pkg::QUOT_W-1:ppr_pkg::DIV_SHIFT];
    end

    assign quot = quot_reg;

endmodule

// File: sim/phone_prefix_range_lookup_tb.sv
// self-checking testbench for the phone prefix range lookup
`timescale 1ns / 1ps

module phone_prefix_range_lookup_tb;

    localparam int RECORD_DEPTH = 524288;
    localparam int PREFIX_COUNT = 1000;
    localparam int PREFIX_DIV   = 10000;
    localparam int MAX_NUMBER   = 9999999;
    localparam int MAX_INDEX    = RECORD_DEPTH - 1;
    localparam int ITEM_TARGET  = 1225;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 500;
    localparam int LIMIT_CYCLES = 600000;

    // input transaction as carried on s_tdata, lowest field last
    typedef struct packed {
        logic [4:0]                   pad;
        logic [ppr_pkg::KEY_W-1:0]    query_number;
        logic [ppr_pkg::CARR_W-1:0]   slot_carrier;
        logic [ppr_pkg::REGION_W-1:0] slot_region;
        logic [ppr_pkg::KEY_W-1:0]    slot_number;
        logic [ppr_pkg::IDX_W-1:0]    slot_index;
        logic [ppr_pkg::IDX_W-1:0]    range_last;
        logic [ppr_pkg::IDX_W-1:0]    range_first;
        logic [ppr_pkg::PCODE_W-1:0]  prefix_code;
    } lookup_item_t;

    // output transaction as carried on m_tdata
    typedef struct packed {
        logic [6:0]                   pad;
        logic [ppr_pkg::CARR_W-1:0]   carrier;
        logic [ppr_pkg::REGION_W-1:0] region;
        logic                         hit;
    } lookup_answer_t;

    class lookup_scoreboard;
        bit [ppr_pkg::IDX_W-1:0] range_first [PREFIX_COUNT];
        bit [ppr_pkg::IDX_W-1:0] range_last  [PREFIX_COUNT];
        bit [ppr_pkg::REC_W-1:0] rec_mem     [RECORD_DEPTH];
        bit                      rec_written [RECORD_DEPTH];
        lookup_answer_t          pending_answers [$];
        int                      errors;

        function new();
            foreach (range_first[i])
            begin
                range_first[i] = '0;
                range_last[i]  = '0;
            end
            errors = 0;
        endfunction

        // walks the search as the block does; missing gives the first unwritten probe
        function void search_number(input bit [ppr_pkg::KEY_W-1:0] key, output bit hit,
                                    output bit [ppr_pkg::REC_W-1:0] rec,
                                    output int missing);
            int          lo;
            int          hi;
            int          mid;
            int          found;
            int unsigned pref;
            hit     = 1'b0;
            rec     = '0;
            missing = -1;
            found   = -1;
            pref    = key / PREFIX_DIV;
            if (pref < PREFIX_COUNT)
            begin
                if (range_last[pref] != 0)
                begin
                    lo = int'(range_first[pref]);
                    hi = int'(range_last[pref]);
                    if (lo == hi)
                        found = lo;
                    else
                        while (lo <= hi)
                        begin
                            mid = (lo + hi) / 2;
                            if (!rec_written[mid])
                            begin
                                missing = mid;
                                break;
                            end
                            if (rec_mem[mid][ppr_pkg::REC_W-1 -: ppr_pkg::KEY_W] == key)
                            begin
                                found = mid;
                                break;
                            end
                            if (rec_mem[mid][ppr_pkg::REC_W-1 -: ppr_pkg::KEY_W] > key)
                                hi = mid - 1;
                            else
                                lo = mid + 1;
                        end
                    if (found >= 0)
                    begin
                        if (!rec_written[found])
                            missing = found;
                        else
                        begin
                            hit = 1'b1;
                            rec = rec_mem[found];
                        end
                    end
                end
            end
        endfunction

        function void note_transaction(input ppr_pkg::cmd_t cmd, input lookup_item_t it);
            bit                      hit;
            bit [ppr_pkg::REC_W-1:0] rec;
            int                      missing;
            lookup_answer_t          ans;
            case (cmd)
                ppr_pkg::CMD_LOAD_PREFIX:
                begin
                    if (it.prefix_code < PREFIX_COUNT)
                    begin
                        range_first[it.prefix_code] = it.range_first;
                        range_last[it.prefix_code]  = it.range_last;
                    end
                end
                ppr_pkg::CMD_LOAD_RECORD:
                begin
                    rec_mem[it.slot_index]     = {it.slot_number, it.slot_region,
                                                  it.slot_carrier};
                    rec_written[it.slot_index] = 1'b1;
                end
                ppr_pkg::CMD_QUERY:
                begin
                    search_number(it.query_number, hit, rec, missing);
                    ans         = '0;
                    ans.hit     = hit;
                    ans.region  = hit ? rec[ppr_pkg::CARR_W +: ppr_pkg::REGION_W] : '0;
                    ans.carrier = hit ? rec[ppr_pkg::CARR_W-1:0] : '0;
                    pending_answers.insert(pending_answers.size(), ans);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_answer(input lookup_answer_t got);
            lookup_answer_t want;
            if (pending_answers.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: hit %0d region %h carrier %h",
                             got.hit, got.region, got.carrier);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.hit !== want.hit || got.region !== want.region ||
                    got.carrier !== want.carrier)
                begin
                    if (errors < 10)
                    begin
                        $display("mismatch: expected hit %0d region %h carrier %h",
                                 want.hit, want.region, want.carrier);
                        $display("          got      hit %0d region %h carrier %h",
                                 got.hit, got.region, got.carrier);
                    end
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // prefix_code, range_first, range_last, slot_index, slot_number, slot_region,
    // slot_carrier, query_number, zero pad
    logic [143:0] s_tdata;
    // cmd
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // hit, region_out, carrier_out, zero pad
    logic [31:0] m_tdata;

    logic hold;
    logic quiet;
    int   sent = 0;
    int   cycles = 0;
    int   recent_numbers [$];

    lookup_scoreboard sb;

    phone_prefix_range_lookup #(
        .RECORD_DEPTH(RECORD_DEPTH),
        .PREFIX_COUNT(PREFIX_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic lookup_item_t random_item();
        lookup_item_t it;
        it.pad          = '0;
        it.prefix_code  = 10'($urandom_range(PREFIX_COUNT - 1));
        it.range_first  = 19'($urandom_range(MAX_INDEX));
        it.range_last   = 19'($urandom_range(MAX_INDEX));
        it.slot_index   = 19'($urandom_range(MAX_INDEX));
        it.slot_number  = 24'($urandom_range(MAX_NUMBER));
        it.slot_region  = 16'($urandom_range(65535));
        it.slot_carrier = 8'($urandom_range(255));
        it.query_number = 24'($urandom_range(MAX_NUMBER));
        return it;
    endfunction

    // offers one transaction and returns at the edge where it is taken
    task automatic send(input ppr_pkg::cmd_t cmd, input lookup_item_t it);
        int gap;
        if (!quiet && $urandom_range(99) < 11)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transaction(cmd, it);
        if (cmd != ppr_pkg::CMD_NONE)
            sent++;
        quiet <= (sent >= 400 && sent < 700);
    endtask

    task automatic load_prefix(input int code, input int first, input int last);
        lookup_item_t it;
        it             = random_item();
        it.prefix_code = 10'(code);
        it.range_first = 19'(first);
        it.range_last  = 19'(last);
        send(ppr_pkg::CMD_LOAD_PREFIX, it);
    endtask

    task automatic load_record(input int idx, input int num, input int region,
                               input int carrier);
        lookup_item_t it;
        it              = random_item();
        it.slot_index   = 19'(idx);
        it.slot_number  = 24'(num);
        it.slot_region  = 16'(region);
        it.slot_carrier = 8'(carrier);
        send(ppr_pkg::CMD_LOAD_RECORD, it);
    endtask

    // fills every record the search would probe unwritten, then queries
    task automatic query(input int number);
        lookup_item_t            it;
        bit                      hit;
        bit [ppr_pkg::REC_W-1:0] rec;
        int                      missing;
        int                      num;
        sb.search_number(24'(number), hit, rec, missing);
        while (missing >= 0)
        begin
            num = (number <= MAX_NUMBER && $urandom_range(3) == 0) ?
                  number : int'($urandom_range(MAX_NUMBER));
            load_record(missing, num, $urandom_range(65535), $urandom_range(255));
            sb.search_number(24'(number), hit, rec, missing);
        end
        it              = random_item();
        it.query_number = 24'(number);
        send(ppr_pkg::CMD_QUERY, it);
    endtask

    // sorted block of records under one prefix, then its range, then lookups
    task automatic build_prefix_block();
        int p;
        int n;
        int base;
        int span;
        int r;
        int k;
        int nums [$];
        p = $urandom_range(PREFIX_COUNT - 1);
        n = ($urandom_range(99) < 5) ? $urandom_range(33, 64) : $urandom_range(1, 12);
        r = $urandom_range(99);
        if (r < 10)
            base = RECORD_DEPTH - n;
        else if (r < 20)
            base = 0;
        else
            base = $urandom_range(RECORD_DEPTH - n);
        span = PREFIX_DIV / n;
        for (int i = 0; i < n; i++)
        begin
            nums.insert(nums.size(), p * PREFIX_DIV + i * span + $urandom_range(span - 1));
            load_record(base + i, nums[i], $urandom_range(65535), $urandom_range(255));
            recent_numbers.insert(recent_numbers.size(), nums[i]);
            if (recent_numbers.size() > 200)
                void'(recent_numbers.pop_front());
        end
        load_prefix(p, base, base + n - 1);
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                query(nums[$urandom_range(n - 1)]);
            else if (r < 85)
                query(p * PREFIX_DIV + $urandom_range(PREFIX_DIV - 1));
            else
                query($urandom_range(MAX_NUMBER));
        end
    endtask

    // receiver: checks each result transaction and stalls at random
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_answer(lookup_answer_t'(m_tdata));
            m_tready <= !hold && (quiet || $urandom_range(99) >= 11);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        hold = 1'b0;
        wait (sent >= 800);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    initial
    begin
        lookup_item_t it;
        int           r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ppr_pkg::CMD_NONE;
        quiet    = 1'b0;
        sb       = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, unused command, prefixes beyond the table
        query(0);
        send(ppr_pkg::CMD_NONE, random_item());
        load_prefix(1000, 5, 5);
        load_prefix(1023, 0, MAX_INDEX);
        query(MAX_NUMBER);
        query(10000000);
        query(16777215);
        // extremes of the record fields
        load_record(0, 0, 65535, 255);
        load_record(MAX_INDEX, MAX_NUMBER, 0, 0);
        load_record(1, 1230005, 16'h1234, 8'h56);
        load_record(2, 1230100, 16'h8001, 8'h80);
        load_record(3, 1231234, 16'h00ff, 8'h01);
        load_record(4, 1239999, 16'hfffe, 8'hfe);
        load_prefix(123, 1, 4);
        query(1231234);
        query(1230005);
        query(1239999);
        query(1230006);
        // single-entry range answers without comparing numbers
        load_prefix(999, MAX_INDEX, MAX_INDEX);
        query(9990000);
        // last of zero marks the prefix absent
        load_prefix(0, 5, 0);
        query(5);
        // reversed range finds nothing
        load_prefix(500, 10, 3);
        query(5000000);
        load_prefix(1, 0, 1);
        query(10000);

        while (sent < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 60)
                build_prefix_block();
            else if (r < 85)
            begin
                if (recent_numbers.size() > 0 && $urandom_range(1) == 1)
                    query(recent_numbers[$urandom_range(recent_numbers.size() - 1)]);
                else
                    query($urandom_range(MAX_NUMBER));
            end
            else if (r < 90)
                load_prefix($urandom_range(1023), $urandom_range(MAX_INDEX),
                            $urandom_range(MAX_INDEX));
            else if (r < 95)
            begin
                it = random_item();
                send(ppr_pkg::CMD_LOAD_RECORD, it);
            end
            else
                send(ppr_pkg::CMD_NONE, random_item());
        end
        s_tvalid <= 1'b0;

        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/ppr_pkg.sv
sv/ppr_prefix_div.sv
sv/phone_prefix_range_lookup.sv
sim/phone_prefix_range_lookup_tb.sv
